// File: src/decimal_digit_integer_sqrt_assert.svh
// Assertion macros for the integer square root block.
// Included by modules that carry concurrent checks; depends on nothing else.
`ifndef DECIMAL_DIGIT_INTEGER_SQRT_ASSERT_SVH
`define DECIMAL_DIGIT_INTEGER_SQRT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on the rising clock edge outside reset.
`define DDIS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddis assertion failed");
// Next-cycle implication, checked on the rising clock edge outside reset.
`define DDIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddis assertion failed");
`else
`define DDIS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DDIS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/ddis_pkg.sv
// Shared constants and types for the integer square root block.
// No dependencies; used by decimal_digit_integer_sqrt.
package ddis_pkg;

    localparam int RADICAND_BITS   = 64;
    localparam int ROOT_BITS       = 32;
    localparam int DEF_INPUT_BITS  = 64;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

endpackage

// File: src/decimal_digit_integer_sqrt.sv
// Top level of the integer square root block: sequencer, registers, output stage.
// Depends on ddis_pkg, ddis_step and decimal_digit_integer_sqrt_assert.svh.
//
//   channel   direction  handshake                      payload
//   input     in         i_in_valid / o_in_ready        i_radicand [63:0]
//   output    out        o_out_valid / i_out_ready      o_root [31:0]
//
// An item is taken in the idle state; the single shared trial-subtract unit then
// resolves one root bit per cycle, one for each bit pair of the radicand, unless
// the last step stalls. The block takes no new item while a root is in work.
// A finished root waits in an output register, so the next item may be taken
// while it is unread; the last step stalls only if that register is still full.
// Reset (synchronous, active low) clears the sequencer and the output valid.
module decimal_digit_integer_sqrt
    #(
    parameter int INPUT_BITS = ddis_pkg::DEF_INPUT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ddis_pkg::RADICAND_BITS-1:0] i_radicand,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ddis_pkg::ROOT_BITS-1:0] o_root
);
    import ddis_pkg::*;

    // The radicand is treated as base-4 digits (bit pairs), one root bit each.
    localparam int PAIRS  = (INPUT_BITS + 1) / 2;
    localparam int RAD_W  = 2 * PAIRS;
    localparam int ROOT_W = PAIRS;
    localparam int REM_W  = ROOT_W + 3;
    localparam int CNT_W  = $clog2(PAIRS);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [RAD_W-1:0]    r_rad, n_rad;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic                r_out_valid, n_out_valid;
    logic [ROOT_BITS-1:0] r_out_root, n_out_root;

    logic [REM_W-1:0]    step_rem;
    logic [ROOT_W-1:0]   step_root;
    logic                in_take;
    logic                out_free;
    logic                last_step;

    ddis_step #(
        .ROOT_W(ROOT_W)
    ) u_step (
        .i_rem  (r_rem),
        .i_root (r_root),
        .i_pair (r_rad[RAD_W-1 -: 2]),
        .o_rem  (step_rem),
        .o_root (step_root)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_take     = i_in_valid & o_in_ready;
    assign out_free    = ~r_out_valid | i_out_ready;
    assign last_step   = (r_cnt == '0);
    assign o_out_valid = r_out_valid;
    assign o_root      = r_out_root;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rad       = r_rad;
        n_rem       = r_rem;
        n_root      = r_root;
        n_out_valid = r_out_valid;
        n_out_root  = r_out_root;

        // The waiting root leaves as soon as the consumer takes it.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    // Bits above INPUT_BITS are dropped here; an odd width
                    // gets a zero bit on top to complete the leading pair.
                    n_rad   = RAD_W'(i_radicand[INPUT_BITS-1:0]);
                    n_rem   = '0;
                    n_root  = '0;
                    n_cnt   = CNT_W'(PAIRS - 1);
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (!last_step) begin
                    n_rad  = r_rad << 2;
                    n_rem  = step_rem;
                    n_root = step_root;
                    n_cnt  = r_cnt - 1'b1;
                end else if (out_free) begin
                    // The final step writes straight into the output register.
                    n_rem       = step_rem;
                    n_root      = step_root;
                    n_out_root  = ROOT_BITS'(step_root);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad      <= n_rad;
        r_rem      <= n_rem;
        r_root     <= n_root;
        r_out_root <= n_out_root;
    end

`include "decimal_digit_integer_sqrt_assert.svh"

    // A newly taken item starts from a cleared root and remainder.
    `DDIS_ASSERT_NEXT(a_start_clear, i_clk, i_rst_n, in_take,
        (r_state == S_RUN) && (r_root == '0) && (r_rem == '0))
    // The remainder stays within twice the partial root during the iteration.
    `DDIS_ASSERT_NOW(a_rem_bound, i_clk, i_rst_n, r_state == S_RUN,
        r_rem <= REM_W'({r_root, 1'b0}))
    // A result appears only after the final step of a running item.
    `DDIS_ASSERT_NOW(a_out_source, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state == S_RUN) && $past(r_cnt == '0))

endmodule

// File: src/ddis_step.sv
// One digit-by-digit square root step: shift in a bit pair, trial subtract.
// Pure combinational unit shared by every iteration; no package dependency.
module ddis_step #(
    parameter int ROOT_W = 32
) (
    input  logic [ROOT_W+2:0] i_rem,
    input  logic [ROOT_W-1:0] i_root,
    input  logic [1:0]        i_pair,
    output logic [ROOT_W+2:0] o_rem,
    output logic [ROOT_W-1:0] o_root
);

    logic [ROOT_W+2:0] shifted;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+3:0] diff;
    logic              fits;

    // The remainder never exceeds twice the partial root, so its top two
    // bits are always zero before the shift.
    assign shifted = {i_rem[ROOT_W:0], i_pair};
    assign trial   = {1'b0, i_root, 2'b01};
    assign diff    = {1'b0, shifted} - {1'b0, trial};
    assign fits    = ~diff[ROOT_W+3];

    assign o_rem  = fits ? diff[ROOT_W+2:0] : shifted;
    assign o_root = {i_root[ROOT_W-2:0], fits};

endmodule
